@@ src/phc_pkg.sv @@
package phc_pkg;

  // Payload of one input and one result transaction
  typedef struct packed {
    logic               kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] angular_cmd;
    logic [14:0]        linear_cmd;
    logic [14:0]        bearing;
  } out_item_t;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_BAND    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_BAND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED = 3'd3;

  localparam logic [14:0] ANGLE_BAND_RST    = 15'd410;
  localparam logic [14:0] DIST_BAND_RST     = 15'd205;
  localparam logic [14:0] TURN_RATE_RST     = 15'd8192;
  localparam logic [14:0] FORWARD_SPEED_RST = 15'd2048;

  // Angles in Q3.12 radians
  localparam logic [15:0] Q_PI       = 16'd12868;
  localparam logic [15:0] Q_HALF_PI  = 16'd6434;
  localparam logic [15:0] Q_3HALF_PI = 16'd19302;
  localparam logic [15:0] Q_TWO_PI   = 16'd25736;

  // CORDIC arctangent table
  localparam int ATAN_LEN = 20;
  localparam int IDX_W    = 5;

  function automatic logic [30:0] atan_q30(input logic [IDX_W-1:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:    v = 31'd843314857;
      5'd1:    v = 31'd497837829;
      5'd2:    v = 31'd263043837;
      5'd3:    v = 31'd133525159;
      5'd4:    v = 31'd67021687;
      5'd5:    v = 31'd33543516;
      5'd6:    v = 31'd16775851;
      5'd7:    v = 31'd8388437;
      5'd8:    v = 31'd4194283;
      5'd9:    v = 31'd2097149;
      5'd10:   v = 31'd1048576;
      5'd11:   v = 31'd524288;
      5'd12:   v = 31'd262144;
      5'd13:   v = 31'd131072;
      5'd14:   v = 31'd65536;
      5'd15:   v = 31'd32768;
      5'd16:   v = 31'd16384;
      5'd17:   v = 31'd8192;
      5'd18:   v = 31'd4096;
      5'd19:   v = 31'd2048;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // Control of the CORDIC unit
  typedef struct packed {
    logic             init;
    logic             step;
    logic [IDX_W-1:0] idx;
  } cordic_ctrl_t;

  // Microprogram
  typedef enum logic [2:0] {
    S_WAIT  = 3'd0,
    S_INIT  = 3'd1,
    S_ITER  = 3'd2,
    S_ROUND = 3'd3,
    S_BEAR  = 3'd4,
    S_EMIT  = 3'd5,
    S_HOLD  = 3'd6
  } upc_t;

  typedef enum logic [2:0] {
    J_NONE        = 3'd0,
    J_ALWAYS      = 3'd1,
    J_NO_FOLLOWER = 3'd2,
    J_AXIS        = 3'd3,
    J_MORE        = 3'd4,
    J_OUT_FREE    = 3'd5
  } jump_t;

  typedef struct packed {
    logic  ready;
    logic  init;
    logic  step;
    logic  round;
    logic  bear;
    logic  emit;
    jump_t jmp;
    upc_t  target;
  } ucode_t;

  // Control store: jump to target when the condition holds, else fall through
  function automatic ucode_t phc_rom(input upc_t pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      S_WAIT: begin
        w.ready  = 1'b1;
        w.jmp    = J_NO_FOLLOWER;
        w.target = S_WAIT;
      end
      S_INIT: begin
        w.init   = 1'b1;
        w.jmp    = J_AXIS;
        w.target = S_BEAR;
      end
      S_ITER: begin
        w.step   = 1'b1;
        w.jmp    = J_MORE;
        w.target = S_ITER;
      end
      S_ROUND: begin
        w.round  = 1'b1;
        w.jmp    = J_NONE;
        w.target = S_WAIT;
      end
      S_BEAR: begin
        w.bear   = 1'b1;
        w.jmp    = J_NONE;
        w.target = S_WAIT;
      end
      S_EMIT: begin
        w.emit   = 1'b1;
        w.jmp    = J_OUT_FREE;
        w.target = S_WAIT;
      end
      S_HOLD: begin
        w.jmp    = J_ALWAYS;
        w.target = S_EMIT;
      end
      default: begin
        w.jmp    = J_ALWAYS;
        w.target = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

@@ src/phc_cordic.sv @@
module phc_cordic import phc_pkg::*; (
  input  logic         clk,
  input  cordic_ctrl_t ctrl,
  input  logic [16:0]  ax,
  input  logic [16:0]  ay,
  output logic [12:0]  angle
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [32:0] z;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [32:0] zr;
  logic signed [14:0] zq;

  // Shifted terms for the current iteration
  assign xs = x >>> ctrl.idx;
  assign ys = y >>> ctrl.idx;

  // Load scaled magnitudes, then rotate toward the x axis one step a cycle
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      x <= {3'b000, ax, 14'd0};
      y <= {3'b000, ay, 14'd0};
      z <= '0;
    end else if (ctrl.step) begin
      if (y > 34'sd0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + $signed({2'b00, atan_q30(ctrl.idx)});
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - $signed({2'b00, atan_q30(ctrl.idx)});
      end
    end
  end

  // Round Q2.30 to Q3.12 and clamp to [0, pi/2]
  assign zr = z + 33'sd131072;
  assign zq = zr[32:18];

  always_comb begin
    if (zq < 15'sd0) begin
      angle = '0;
    end else if (zq > $signed({1'b0, Q_HALF_PI[13:0]})) begin
      angle = Q_HALF_PI[12:0];
    end else begin
      angle = zq[12:0];
    end
  end

endmodule

@@ src/pursuit_heading_controller.sv @@
// Pursuit heading controller: steers a follower toward a stored leader position.
// Input channel (in_valid/in_ready/in_data): kind 0 stores the leader position
// and yields no result; kind 1 carries the follower position and heading and
// yields one result on the output channel (out_valid/out_ready/out_data) with
// the bearing to the leader in [0, 2pi), a turn command and a forward command.
// A leader transaction is taken in the wait step. A follower transaction is worked by a
// small microprogram around one shared CORDIC iteration unit: init, the CORDIC
// iterations, round, bearing and emit steps, in that order (init goes straight to the
// bearing step when the leader lies on an axis through the follower, as no iterations
// run); the next transaction is taken only once the sequencer is back in its wait step.
// The result sits in an output register; a stalled receiver holds it there and
// the sequencer loops between its emit and hold steps until the register is free,
// while in_ready stays low. The cfg port writes angle_band, dist_band, turn_rate and
// forward_speed by index and should be used only when the block is idle.
// Synchronous reset restores register defaults, clears the leader position to
// the origin, drops any pending result and returns the sequencer to its wait step.
module pursuit_heading_controller import phc_pkg::*; #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NSTEPS - 1);

  logic [14:0]        angle_band;
  logic [14:0]        dist_band;
  logic [14:0]        turn_rate;
  logic [14:0]        forward_speed;
  logic signed [15:0] leader_x;
  logic signed [15:0] leader_y;

  upc_t               pc;
  upc_t               pc_next;
  ucode_t             uw;
  logic               cond;
  logic [IDX_W-1:0]   cnt;

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [15:0] heading;
  logic [16:0]        adx;
  logic [16:0]        ady;
  logic [12:0]        qangle;
  logic [12:0]        cangle;
  logic [14:0]        brg;
  logic [15:0]        brg_next;
  logic               on_axis;
  logic               out_free;

  logic signed [17:0] err;
  logic signed [17:0] band_s;
  logic signed [15:0] ang;
  logic [14:0]        lin;

  cordic_ctrl_t       cctrl;

  // Decode the current control word
  assign uw       = phc_rom(pc);
  assign in_ready = uw.ready;
  assign out_free = !out_valid || out_ready;
  assign on_axis  = (dx == 17'sd0) || (dy == 17'sd0);

  always_comb begin
    unique case (uw.jmp)
      J_NONE:        cond = 1'b0;
      J_ALWAYS:      cond = 1'b1;
      J_NO_FOLLOWER: cond = !(in_valid && in_data.kind);
      J_AXIS:        cond = on_axis;
      J_MORE:        cond = (cnt != LAST);
      J_OUT_FREE:    cond = out_free;
      default:       cond = 1'b1;
    endcase
    pc_next = cond ? uw.target : upc_t'(pc + 3'd1);
  end

  // Sequencer and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= S_WAIT;
      cnt           <= '0;
      angle_band    <= ANGLE_BAND_RST;
      dist_band     <= DIST_BAND_RST;
      turn_rate     <= TURN_RATE_RST;
      forward_speed <= FORWARD_SPEED_RST;
      leader_x      <= '0;
      leader_y      <= '0;
    end else begin
      pc <= pc_next;
      if (uw.init) begin
        cnt <= '0;
      end else if (uw.step) begin
        cnt <= cnt + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ANGLE_BAND:    angle_band    <= cfg_data;
          REG_DIST_BAND:     dist_band     <= cfg_data;
          REG_TURN_RATE:     turn_rate     <= cfg_data;
          REG_FORWARD_SPEED: forward_speed <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready && !in_data.kind) begin
        leader_x <= in_data.pos_x;
        leader_y <= in_data.pos_y;
      end
    end
  end

  // Magnitudes of the offsets, ready for the CORDIC load
  assign adx = dx[16] ? (~dx + 17'd1) : dx;
  assign ady = dy[16] ? (~dy + 17'd1) : dy;

  // Capture the follower transaction and its offsets to the leader, and the rounded angle and bearing in their steps
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.kind) begin
      dx      <= {leader_x[15], leader_x} - {in_data.pos_x[15], in_data.pos_x};
      dy      <= {leader_y[15], leader_y} - {in_data.pos_y[15], in_data.pos_y};
      heading <= in_data.heading;
    end
    if (uw.round) begin
      qangle <= cangle;
    end
    if (uw.bear) begin
      brg <= brg_next[14:0];
    end
  end

  // Shared CORDIC iteration unit
  assign cctrl.init = uw.init;
  assign cctrl.step = uw.step;
  assign cctrl.idx  = cnt;

  phc_cordic u_cordic (
    .clk   (clk),
    .ctrl  (cctrl),
    .ax    (adx),
    .ay    (ady),
    .angle (cangle)
  );

  // Quadrant correction and on-axis cases
  always_comb begin
    if (dy == 17'sd0) begin
      brg_next = dx[16] ? Q_PI : 16'd0;
    end else if (dx == 17'sd0) begin
      brg_next = dy[16] ? Q_3HALF_PI : Q_HALF_PI;
    end else if (!dx[16] && !dy[16]) begin
      brg_next = {3'b000, qangle};
    end else if (dx[16] && !dy[16]) begin
      brg_next = Q_PI - {3'b000, qangle};
    end else if (dx[16]) begin
      brg_next = Q_PI + {3'b000, qangle};
    end else begin
      brg_next = Q_TWO_PI - {3'b000, qangle};
    end
    if (brg_next >= Q_TWO_PI) begin
      brg_next = 16'd0;
    end
  end

  // Turn and forward decisions
  assign err    = $signed({3'b000, brg}) - $signed({{2{heading[15]}}, heading});
  assign band_s = $signed({3'b000, angle_band});

  always_comb begin
    if (err > band_s) begin
      ang = $signed({1'b0, turn_rate});
    end else if (err < -band_s) begin
      ang = -$signed({1'b0, turn_rate});
    end else begin
      ang = '0;
    end
    if (ang == 16'sd0 && adx > {2'b00, dist_band} && ady > {2'b00, dist_band}) begin
      lin = forward_speed;
    end else begin
      lin = '0;
    end
  end

  // Output register: load on emit when free, drop on a completed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit && out_free) begin
      out_data.angular_cmd <= ang;
      out_data.linear_cmd  <= lin;
      out_data.bearing     <= brg;
    end
  end

  // Checks
  a_brg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_data.bearing} < Q_TWO_PI))
    else $error("bearing out of range");

  a_turn_or_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.linear_cmd == 15'd0 || out_data.angular_cmd == 16'sd0))
    else $error("forward command issued while turning");

  a_turn_value: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.angular_cmd == 16'sd0
                || out_data.angular_cmd == $signed({1'b0, turn_rate})
                || out_data.angular_cmd == -$signed({1'b0, turn_rate})))
    else $error("turn command not zero or +/- turn_rate");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (pc == S_ITER) |-> (cnt <= LAST))
    else $error("CORDIC iteration count overrun");

  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(pc) == S_EMIT))
    else $error("result loaded outside the emit step");

endmodule

@@ test/pursuit_heading_controller_test.sv @@
`timescale 1ns / 100ps

module pursuit_heading_controller_test;
  import phc_pkg::*;

  localparam int CORDIC_STEPS  = 14;
  localparam int SETTLE_CYCLES = CORDIC_STEPS + 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int PHASES        = 6;

  localparam logic KIND_LEADER   = 1'b0;
  localparam logic KIND_FOLLOWER = 1'b1;

  localparam int PI_Q12         = Q_PI;
  localparam int HALF_PI_Q12    = Q_HALF_PI;
  localparam int THREE_HALF_Q12 = Q_3HALF_PI;
  localparam int TWO_PI_Q12     = Q_TWO_PI;
  localparam logic [14:0] REG_MAX = 15'h7fff;

  // atan(2^-i) in Q2.30
  longint arctan_q30 [0:19] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;

  // Shadow of the block's registers and leader position
  logic [14:0]        m_angle_band    = ANGLE_BAND_RST;
  logic [14:0]        m_dist_band     = DIST_BAND_RST;
  logic [14:0]        m_turn_rate     = TURN_RATE_RST;
  logic [14:0]        m_forward_speed = FORWARD_SPEED_RST;
  logic signed [15:0] m_lead_x        = '0;
  logic signed [15:0] m_lead_y        = '0;

  out_item_t steer_due [$];
  int        mismatches    = 0;
  int        results_seen  = 0;
  int        leader_sent   = 0;
  int        follower_sent = 0;
  int        settings_used = 0;
  int        cycles        = 0;
  bit        calm          = 1'b0;

  pursuit_heading_controller #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int either_sign(int mag);
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  // First-quadrant angle by CORDIC vectoring, Q3.12 in [0, pi/2]
  function automatic int quadrant_angle_q12(longint ax, longint ay);
    longint x, y, z, xs, ys;
    x = ax * 16384;
    y = ay * 16384;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_q30[i];
      end
    end
    z = (z + 131072) >>> 18;
    if (z < 0) z = 0;
    if (z > HALF_PI_Q12) z = HALF_PI_Q12;
    return int'(z);
  endfunction

  // Bearing in [0, 2pi) with the axis cases fixed
  function automatic int bearing_q12(int dx, int dy);
    int a, b;
    if (dy == 0) return (dx >= 0) ? 0 : PI_Q12;
    if (dx == 0) return (dy > 0) ? HALF_PI_Q12 : THREE_HALF_Q12;
    a = quadrant_angle_q12(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
    if (dx > 0 && dy > 0) b = a;
    else if (dx < 0 && dy > 0) b = PI_Q12 - a;
    else if (dx < 0) b = PI_Q12 + a;
    else b = TWO_PI_Q12 - a;
    if (b >= TWO_PI_Q12) b = 0;
    return b;
  endfunction

  // Update the leader, or queue the steering command a follower should get
  function automatic void predict_steering(in_item_t it);
    int dx, dy, brg, err, ang;
    logic [14:0] lin;
    out_item_t res;
    if (it.kind == KIND_LEADER) begin
      m_lead_x = it.pos_x;
      m_lead_y = it.pos_y;
      return;
    end
    dx  = int'(m_lead_x) - int'($signed(it.pos_x));
    dy  = int'(m_lead_y) - int'($signed(it.pos_y));
    brg = bearing_q12(dx, dy);
    err = brg - int'($signed(it.heading));
    ang = 0;
    if (err > int'(m_angle_band)) ang = int'(m_turn_rate);
    else if (err < -int'(m_angle_band)) ang = -int'(m_turn_rate);
    lin = '0;
    if (ang == 0 && (dx < 0 ? -dx : dx) > int'(m_dist_band) &&
        (dy < 0 ? -dy : dy) > int'(m_dist_band))
      lin = m_forward_speed;
    res.angular_cmd = ang[15:0];
    res.linear_cmd  = lin;
    res.bearing     = brg[14:0];
    steer_due.push_back(res);
  endfunction

  function automatic in_item_t make_item(logic kind, int x, int y, int hd);
    in_item_t it;
    it.kind    = kind;
    it.pos_x   = 16'(x);
    it.pos_y   = 16'(y);
    it.heading = 16'(hd);
    return it;
  endfunction

  // Follower placed to hit axes, deadband edges and heading band edges often
  function automatic in_item_t random_follower();
    int x, y, brg, off;
    in_item_t it;
    x = m_lead_x;
    y = m_lead_y;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        x = $urandom;
        y = $urandom;
      end
      3, 4, 5: begin
        x = x + either_sign($urandom_range(0, 600));
        y = y + either_sign($urandom_range(0, 600));
      end
      6: y = $urandom;
      7: x = $urandom;
      8: ;
      default: begin
        x = x + either_sign(int'(m_dist_band) + $urandom_range(0, 2) - 1);
        y = y + either_sign(int'(m_dist_band) + $urandom_range(0, 2) - 1);
      end
    endcase
    it = make_item(KIND_FOLLOWER, x, y, $urandom);
    if ($urandom_range(0, 3) != 0) begin
      brg = bearing_q12(int'(m_lead_x) - int'($signed(it.pos_x)),
                        int'(m_lead_y) - int'($signed(it.pos_y)));
      if ($urandom_range(0, 1))
        off = either_sign(int'(m_angle_band) + $urandom_range(0, 2) - 1);
      else
        off = $urandom_range(0, 2 * int'(m_angle_band) + 2) - int'(m_angle_band) - 1;
      it.heading = 16'(brg - off);
    end
    return it;
  endfunction

  // Present one transaction and hold it until the block takes it
  task automatic send_item(in_item_t it);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_steering(it);
    if (it.kind == KIND_LEADER) leader_sent++;
    else follower_sent++;
  endtask

  // Follower whose heading error comes out as off
  task automatic steer_at_offset(int x, int y, int off);
    int brg;
    brg = bearing_q12(int'(m_lead_x) - x, int'(m_lead_y) - y);
    send_item(make_item(KIND_FOLLOWER, x, y, brg - off));
  endtask

  // Drop valid, wait for every result, then let the pipeline go quiet
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (steer_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [14:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ANGLE_BAND:    m_angle_band    = val;
      REG_DIST_BAND:     m_dist_band     = val;
      REG_TURN_RATE:     m_turn_rate     = val;
      REG_FORWARD_SPEED: m_forward_speed = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [14:0] ab, logic [14:0] db, logic [14:0] tr,
                              logic [14:0] fs);
    cfg_write(REG_ANGLE_BAND, ab);
    cfg_write(REG_DIST_BAND, db);
    // unmapped index must leave everything alone
    cfg_write(REG_FORWARD_SPEED + 3'($urandom_range(1, 4)), 15'($urandom));
    cfg_write(REG_TURN_RATE, tr);
    cfg_write(REG_FORWARD_SPEED, fs);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Same position, all four axis directions, all four quadrants, far corners
  task automatic test_bearing_geometry();
    send_item(make_item(KIND_FOLLOWER, 0, 0, 0));
    send_item(make_item(KIND_LEADER, 1000, 500, 0));
    send_item(make_item(KIND_FOLLOWER, 0, 500, 0));
    send_item(make_item(KIND_FOLLOWER, 2000, 500, 32767));
    send_item(make_item(KIND_FOLLOWER, 1000, -3000, -32768));
    send_item(make_item(KIND_FOLLOWER, 1000, 4000, THREE_HALF_Q12));
    send_item(make_item(KIND_FOLLOWER, 0, 0, 100));
    send_item(make_item(KIND_FOLLOWER, 2000, 0, 9000));
    send_item(make_item(KIND_FOLLOWER, 2000, 1000, 16000));
    send_item(make_item(KIND_FOLLOWER, 0, 1000, 24000));
    send_item(make_item(KIND_LEADER, 32767, 32767, 0));
    send_item(make_item(KIND_FOLLOWER, -32768, -32768, 0));
    send_item(make_item(KIND_FOLLOWER, -32768, 32766, 1));
    send_item(make_item(KIND_LEADER, -32768, -32768, -1));
    send_item(make_item(KIND_FOLLOWER, 32767, 32767, -32768));
  endtask

  // Heading error and distance right at the deadband edges
  task automatic test_turn_and_drive_bands();
    send_item(make_item(KIND_LEADER, 0, 0, 0));
    steer_at_offset(-300, -300, int'(m_angle_band));
    steer_at_offset(-300, -300, int'(m_angle_band) + 1);
    steer_at_offset(-300, -300, -int'(m_angle_band));
    steer_at_offset(-300, -300, -int'(m_angle_band) - 1);
    steer_at_offset(-int'(m_dist_band), -300, 0);
  endtask

  // Zero and full-scale register values
  task automatic test_register_extremes();
    drain_and_settle();
    program_regs('0, '0, '0, REG_MAX);
    steer_at_offset(-1, -1, 5);
    send_item(make_item(KIND_FOLLOWER, 0, -5, 0));
    drain_and_settle();
    program_regs(REG_MAX, REG_MAX, REG_MAX, '0);
    send_item(make_item(KIND_FOLLOWER, 32767, 32767, -32768));
    send_item(make_item(KIND_FOLLOWER, -32768, 5, 32767));
    send_item(make_item(KIND_FOLLOWER, -32768, -32768, 0));
  endtask

  // Random pursuit traffic over several register settings
  task automatic test_random_pursuit();
    logic [14:0] ab, db, tr, fs;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          ab = ANGLE_BAND_RST;
          db = DIST_BAND_RST;
          tr = TURN_RATE_RST;
          fs = FORWARD_SPEED_RST;
        end
        1: begin
          ab = '0;
          db = '0;
          tr = '0;
          fs = '0;
        end
        2: begin
          ab = REG_MAX;
          db = REG_MAX;
          tr = REG_MAX;
          fs = REG_MAX;
        end
        default: begin
          ab = $urandom_range(0, 3000);
          db = $urandom_range(0, 8000);
          tr = 15'($urandom);
          fs = 15'($urandom);
        end
      endcase
      drain_and_settle();
      program_regs(ab, db, tr, fs);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if ($urandom_range(0, 59) == 0) calm = !calm;
        if ($urandom_range(0, 3) == 0)
          send_item(make_item(KIND_LEADER, $urandom, $urandom, $urandom));
        else
          send_item(random_follower());
      end
    end
    calm = 1'b0;
  endtask

  // Receiver side: stall at random, except in calm stretches
  initial begin : drive_out_ready
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold = calm ? 0 : pick_gap();
      end
    end
  end

  // Compare each result transaction with the oldest pending command
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (steer_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending: angular %0d linear %0d bearing %0d",
                 $time, $signed(out_data.angular_cmd), out_data.linear_cmd,
                 out_data.bearing);
      end else begin
        want = steer_due.pop_front();
        if (out_data.angular_cmd !== want.angular_cmd) begin
          mismatches++;
          $display("%0t: angular_cmd expected %0d actual %0d", $time,
                   $signed(want.angular_cmd), $signed(out_data.angular_cmd));
        end
        if (out_data.linear_cmd !== want.linear_cmd) begin
          mismatches++;
          $display("%0t: linear_cmd expected %0d actual %0d", $time,
                   want.linear_cmd, out_data.linear_cmd);
        end
        if (out_data.bearing !== want.bearing) begin
          mismatches++;
          $display("%0t: bearing expected %0d actual %0d", $time,
                   want.bearing, out_data.bearing);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d results pending", $time,
               cycles, steer_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : run
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_bearing_geometry();
    test_turn_and_drive_bands();
    test_register_extremes();
    test_random_pursuit();
    drain_and_settle();
    $display("Sent %0d leader and %0d follower transactions under %0d register settings.",
             leader_sent, follower_sent, settings_used);
    $display("Checked %0d steering results, %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0 && steer_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
src/phc_pkg.sv
src/phc_cordic.sv
src/pursuit_heading_controller.sv
test/pursuit_heading_controller_test.sv
